[sv/cmdtok_pkg.sv]
// Shared types and codes for the command line tokenizer.
package cmdtok_pkg;

	localparam int MAX_RES = 4;

	typedef enum logic [1:0] {
		K_ARG  = 2'd0,
		K_FILE = 2'd1,
		K_END  = 2'd2
	} kind_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_QUOTE  = 2'd1;
	localparam logic [1:0] ST_ESCAPE = 2'd2;
	localparam logic [1:0] ST_NOFILE = 2'd3;

	localparam logic [1:0] RD_NONE   = 2'd0;
	localparam logic [1:0] RD_NEW    = 2'd1;
	localparam logic [1:0] RD_APPEND = 2'd2;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [1:0]  status;
		logic [1:0]  redir;
		logic [5:0]  count;
	} result_t;

	typedef struct packed {
		result_t [MAX_RES-1:0] res;
		logic [2:0]            n;
	} batch_t;

endpackage

[sv/cmdtok_lexer.sv]
// Lexer state and the single-pass step that turns one byte into a batch of results.
module cmdtok_lexer import cmdtok_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_s1,
	input  logic       last_s1,
	input  logic [5:0] arg_limit,
	output batch_t     batch
);

	typedef enum logic [7:0] {
		M_BETWEEN   = 8'b0000_0001,
		M_TOKEN     = 8'b0000_0010,
		M_ESC       = 8'b0000_0100,
		M_SQESC     = 8'b0000_1000,
		M_OCT       = 8'b0001_0000,
		M_HEX       = 8'b0010_0000,
		M_REDIR1    = 8'b0100_0000,
		M_REDIRWAIT = 8'b1000_0000
	} mode_t;

	typedef enum logic [1:0] {
		Q_NONE   = 2'd0,
		Q_SINGLE = 2'd1,
		Q_DOUBLE = 2'd2
	} quote_t;

	typedef struct packed {
		mode_t      mode;
		quote_t     quote;
		logic [7:0] dv;
		logic [2:0] dc;
		logic [5:0] args;
		logic [1:0] redir;
		logic [1:0] err;
		logic       in_fn;
		logic       halted;
	} lex_t;

	typedef struct packed {
		lex_t   st;
		batch_t out;
	} work_t;

	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_DQ  = 8'h22;
	localparam logic [7:0] CH_SQ  = 8'h27;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_7   = 8'h37;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_GT  = 8'h3E;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LF_ = 8'h66;
	localparam logic [7:0] CH_N   = 8'h6E;
	localparam logic [7:0] CH_R   = 8'h72;
	localparam logic [7:0] CH_X   = 8'h78;

	localparam lex_t LEX_IDLE = '{
		mode: M_BETWEEN, quote: Q_NONE, dv: 8'd0, dc: 3'd0, args: 6'd0,
		redir: RD_NONE, err: ST_OK, in_fn: 1'b0, halted: 1'b0
	};

	lex_t  st_q;
	work_t w;

	function automatic logic f_ws(logic [7:0] b);
		return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
	endfunction

	// Returns {valid, value} for a hex digit of either case.
	function automatic logic [4:0] f_hex(logic [7:0] b);
		logic [7:0] d;
		d = 8'd0;
		if (b >= CH_0 && b <= CH_9) begin
			d = b - CH_0;
			return {1'b1, d[3:0]};
		end
		if (b >= CH_LA && b <= CH_LF_) begin
			d = b - CH_LA + 8'd10;
			return {1'b1, d[3:0]};
		end
		if (b >= CH_UA && b <= CH_UF) begin
			d = b - CH_UA + 8'd10;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

	function automatic work_t f_put(work_t x, result_t r);
		if (x.out.n < 3'(MAX_RES)) begin
			x.out.res[x.out.n[1:0]] = r;
			x.out.n = x.out.n + 3'd1;
		end
		return x;
	endfunction

	function automatic work_t f_emit(work_t x, logic [7:0] b);
		result_t r;
		r = '0;
		r.kind = x.st.in_fn ? K_FILE : K_ARG;
		r.data = b;
		return f_put(x, r);
	endfunction

	function automatic work_t f_fail(work_t x, logic [1:0] code);
		x.st.err = code;
		x.st.halted = 1'b1;
		return x;
	endfunction

	function automatic work_t f_close(work_t x);
		x = f_emit(x, 8'd0);
		if (!x.st.in_fn) x.st.args = x.st.args + 6'd1;
		x.st.in_fn = 1'b0;
		x.st.quote = Q_NONE;
		x.st.mode = M_BETWEEN;
		return x;
	endfunction

	// A token that begins with '>' is a redirect, subject to the argument limit.
	function automatic work_t f_start_redir(work_t x, logic [5:0] lim);
		if (x.st.args >= lim) begin
			x.st.halted = 1'b1;
		end else begin
			x.st.redir = RD_NEW;
			x.st.mode = M_REDIR1;
		end
		return x;
	endfunction

	function automatic work_t f_token_byte(work_t x, logic [7:0] b, logic [5:0] lim);
		quote_t q;
		q = (b == CH_SQ) ? Q_SINGLE : Q_DOUBLE;
		if (b == CH_BSL) begin
			if (x.st.quote == Q_SINGLE) begin
				x = f_emit(x, b);
				x.st.mode = M_SQESC;
			end else begin
				x.st.mode = M_ESC;
			end
		end else if (x.st.quote == Q_NONE && f_ws(b)) begin
			x = f_close(x);
		end else if (x.st.quote == Q_NONE && b == CH_GT) begin
			x = f_close(x);
			x = f_start_redir(x, lim);
		end else if (b == CH_DQ || b == CH_SQ) begin
			if (x.st.quote == Q_NONE) x.st.quote = q;
			else if (x.st.quote == q) x.st.quote = Q_NONE;
			else x = f_emit(x, b);
		end else begin
			x = f_emit(x, b);
		end
		return x;
	endfunction

	function automatic work_t f_start_token(work_t x, logic [7:0] b, logic [5:0] lim);
		if (x.st.args >= lim) begin
			x.st.halted = 1'b1;
		end else if (b == CH_GT) begin
			x = f_start_redir(x, lim);
		end else begin
			x.st.in_fn = 1'b0;
			x.st.quote = Q_NONE;
			x.st.mode = M_TOKEN;
			x = f_token_byte(x, b, lim);
		end
		return x;
	endfunction

	function automatic work_t f_start_file(work_t x, logic [7:0] b, logic [5:0] lim);
		x.st.in_fn = 1'b1;
		x.st.quote = Q_NONE;
		x.st.mode = M_TOKEN;
		return f_token_byte(x, b, lim);
	endfunction

	function automatic work_t f_finish(work_t x);
		if (x.st.dv == 8'd0) begin
			x = f_fail(x, ST_ESCAPE);
		end else begin
			x = f_emit(x, x.st.dv);
			x.st.mode = M_TOKEN;
		end
		return x;
	endfunction

	function automatic work_t f_take(work_t x, logic [7:0] b, logic [5:0] lim);
		logic [4:0] h;
		h = f_hex(b);
		unique case (x.st.mode)
			M_TOKEN: begin
				x = f_token_byte(x, b, lim);
			end
			M_ESC: begin
				x.st.dv = 8'd0;
				x.st.dc = 3'd0;
				if (b == CH_N) begin
					x = f_emit(x, CH_LF);
					x.st.mode = M_TOKEN;
				end else if (b == CH_R) begin
					x = f_emit(x, CH_CR);
					x.st.mode = M_TOKEN;
				end else if (b == CH_0) begin
					x.st.mode = M_OCT;
				end else if (b == CH_X) begin
					x.st.mode = M_HEX;
				end else begin
					x = f_emit(x, b);
					x.st.mode = M_TOKEN;
				end
			end
			M_SQESC: begin
				x = f_emit(x, b);
				x.st.mode = M_TOKEN;
			end
			M_OCT: begin
				if (b >= CH_0 && b <= CH_7) begin
					x.st.dv = {x.st.dv[4:0], b[2:0]};
					x.st.dc = x.st.dc + 3'd1;
					if (x.st.dc >= 3'd4) x = f_finish(x);
				end else if (x.st.dc < 3'd2) begin
					x = f_fail(x, ST_ESCAPE);
				end else begin
					// The digit run ends here and the byte is taken as token text.
					x = f_finish(x);
					if (!x.st.halted) x = f_token_byte(x, b, lim);
				end
			end
			M_HEX: begin
				if (!h[4]) begin
					x = f_fail(x, ST_ESCAPE);
				end else begin
					x.st.dv = {x.st.dv[3:0], h[3:0]};
					x.st.dc = x.st.dc + 3'd1;
					if (x.st.dc >= 3'd2) x = f_finish(x);
				end
			end
			M_REDIR1: begin
				if (f_ws(b)) begin
					x.st.mode = M_REDIRWAIT;
				end else if (b == CH_GT) begin
					x.st.redir = RD_APPEND;
					x.st.mode = M_REDIRWAIT;
				end else begin
					x = f_start_file(x, b, lim);
				end
			end
			M_REDIRWAIT: begin
				if (f_ws(b)) begin
					x.st.mode = M_REDIRWAIT;
				end else if (b == CH_GT) begin
					// An empty filename closes the old redirect before the new one.
					x.st.in_fn = 1'b1;
					x = f_emit(x, 8'd0);
					x.st.in_fn = 1'b0;
					x.st.mode = M_BETWEEN;
					x = f_start_token(x, b, lim);
				end else begin
					x = f_start_file(x, b, lim);
				end
			end
			default: begin
				x.st.mode = M_BETWEEN;
				if (!f_ws(b)) x = f_start_token(x, b, lim);
			end
		endcase
		return x;
	endfunction

	function automatic work_t f_end(work_t x);
		result_t r;
		if (!x.st.halted) begin
			unique case (x.st.mode)
				M_REDIR1, M_REDIRWAIT: x = f_fail(x, ST_NOFILE);
				M_HEX: x = f_fail(x, ST_ESCAPE);
				M_OCT: begin
					if (x.st.dc < 3'd2) begin
						x = f_fail(x, ST_ESCAPE);
					end else begin
						x = f_finish(x);
						if (!x.st.halted) begin
							if (x.st.quote != Q_NONE) x = f_fail(x, ST_QUOTE);
							else x = f_close(x);
						end
					end
				end
				M_TOKEN, M_ESC, M_SQESC: begin
					if (x.st.quote != Q_NONE) x = f_fail(x, ST_QUOTE);
					else x = f_close(x);
				end
				default: x.st.mode = M_BETWEEN;
			endcase
		end
		r = '0;
		r.kind = K_END;
		r.status = x.st.err;
		r.redir = x.st.redir;
		r.count = x.st.args;
		x = f_put(x, r);
		x.st = LEX_IDLE;
		return x;
	endfunction

	always_comb begin
		w.st = st_q;
		w.out = '0;
		if (byte_s1 == 8'd0) begin
			w = f_end(w);
		end else begin
			if (!w.st.halted) w = f_take(w, byte_s1, arg_limit);
			if (last_s1) w = f_end(w);
		end
	end

	assign batch = w.out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LEX_IDLE;
		end else if (step) begin
			st_q <= w.st;
		end
	end

endmodule

[sv/command_line_tokenizer.sv]
// Top level of the command line tokenizer: input register, lexer and result buffer.
//
// Bytes of a command line enter on the input channel (in_valid, in_stall, byte_in,
// line_end), one item per byte. Each byte is split by the lexer into zero to four
// result items on the output channel (out_valid, out_stall): argument bytes,
// redirect filename bytes, and a closing end item carrying status, redirect mode
// and argument count. run_last marks the final result caused by one input byte.
// A zero byte, or any byte with line_end set, closes the line.
//
// An accepted item waits in the input register until the buffer is free; then the
// lexer step runs and loads all its results into a four-entry output buffer, from
// which the first result is offered. The buffer hands out one result per cycle
// while out_stall is low. An item with several results holds the output side
// until they have all left; that buffer drain is what sets the rate.
//
// A stall on the output holds the current result and, once the input register is
// full behind it, raises in_stall. Reset empties both registers, returns the lexer
// to the start of a line and sets the argument slot count to 16. cfg_wr_en writes
// the slot count; use it only while the block is idle, which it does not enforce.
module command_line_tokenizer import cmdtok_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_in,
	input  logic       line_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic [1:0] status,
	output logic [1:0] redirect_mode,
	output logic [5:0] arg_count,
	output logic       run_last
);

	logic [6:0]  arg_slots_q;
	logic [5:0]  arg_limit;

	logic        item_valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	result_t [MAX_RES-1:0] res_q;
	logic [2:0]  rem_q;
	logic [1:0]  head_q;

	batch_t      batch;
	logic        out_take;
	logic        in_take;
	logic        buf_free;
	logic        step;
	result_t     head_res;

	// Argument slots: the last slot is reserved; the limit is the slot count minus one, from 0 to 63.
	always_comb begin
		if (arg_slots_q <= 7'd1) arg_limit = 6'd0;
		else if (arg_slots_q > 7'd64) arg_limit = 6'd63;
		else arg_limit = 6'(arg_slots_q - 7'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arg_slots_q <= 7'd16;
		end else if (cfg_wr_en) begin
			arg_slots_q <= cfg_wr_data;
		end
	end

	// The buffer can take a new batch when it is empty or its last result leaves now.
	assign out_valid = (rem_q != 3'd0);
	assign out_take  = out_valid && !out_stall;
	assign buf_free  = (rem_q == 3'd0) || ((rem_q == 3'd1) && out_take);
	assign step      = item_valid_s1 && buf_free;
	assign in_stall  = item_valid_s1 && !buf_free;
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_take) begin
			item_valid_s1 <= 1'b1;
		end else if (step) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= byte_in;
			last_s1 <= line_end;
		end
	end

	cmdtok_lexer u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_s1   (byte_s1),
		.last_s1   (last_s1),
		.arg_limit (arg_limit),
		.batch     (batch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= 3'd0;
			head_q <= 2'd0;
		end else if (step) begin
			rem_q  <= batch.n;
			head_q <= 2'd0;
		end else if (out_take) begin
			rem_q  <= rem_q - 3'd1;
			head_q <= head_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= batch.res;
		end
	end

	assign head_res      = res_q[head_q];
	assign kind          = head_res.kind;
	assign out_byte      = head_res.data;
	assign status        = head_res.status;
	assign redirect_mode = head_res.redir;
	assign arg_count     = head_res.count;
	assign run_last      = (rem_q == 3'd1);

	// The buffer never holds more than four results.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q <= 3'(MAX_RES)))
		else $error("result buffer count out of range");

	// Head plus remaining results stays within the buffer.
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, head_q} + rem_q) <= 3'(MAX_RES))
		else $error("result buffer head overruns its batch");

	// A line-closing byte always ends its batch with an end item.
	a_line_close: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (last_s1 || byte_s1 == 8'd0)) |->
		(batch.n != 3'd0) && (batch.res[2'(batch.n - 3'd1)].kind == K_END))
		else $error("line end without end item");

	// An end item is always the last result of its byte.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && head_res.kind == K_END) |-> run_last)
		else $error("end item not marked as last result");

endmodule

[bench/testbench.sv]
// Self-checking testbench for the command line tokenizer: directed lines, random lines, pressure.
module testbench;
	import cmdtok_pkg::*;

	// Run limits.
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD_CYCLES = 40;

	// Bytes with a meaning to the lexer.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DIG0   = 8'h30;
	localparam logic [7:0] CH_DIG7   = 8'h37;
	localparam logic [7:0] CH_DIG9   = 8'h39;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_LO_N   = 8'h6E;
	localparam logic [7:0] CH_LO_R   = 8'h72;
	localparam logic [7:0] CH_LO_X   = 8'h78;

	localparam string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzABCXYZ89-_./=";
	localparam string HEX_CHARS  = "0123456789abcdefABCDEF";

	typedef enum logic [3:0] {
		LX_BETWEEN, LX_TOKEN, LX_ESC, LX_SQESC, LX_OCT, LX_HEX, LX_REDIR1, LX_REDIRWAIT
	} lex_t;

	typedef enum logic [1:0] {
		QT_NONE, QT_SINGLE, QT_DOUBLE
	} quote_t;

	// One predicted output item, including the flag that closes the byte's run.
	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		logic [1:0] status;
		logic [1:0] redir;
		logic [5:0] count;
		bit         last;
	} outcome_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [6:0] cfg_wr_data;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] byte_in;
	logic       line_end;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic [1:0] redirect_mode;
	logic [5:0] arg_count;
	logic       run_last;

	command_line_tokenizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.line_end(line_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.out_byte(out_byte),
		.status(status),
		.redirect_mode(redirect_mode),
		.arg_count(arg_count),
		.run_last(run_last)
	);

	always #4 clk = ~clk;

	// Predicted output items in the order the block has to produce them.
	outcome_t tokens_due[$];
	outcome_t step_out[$];
	int error_count = 0;
	int items_sent = 0;
	int cycle_count = 0;

	// Idling control. The stimulus process asks for a long receiver hold by
	// bumping hold_asked; the receiver process notices and counts the hold itself.
	bit idle_on = 1'b1;
	int hold_asked = 0;

	// Mirror of the lexer state.
	logic [6:0] p_arg_slots;
	lex_t       p_mode;
	quote_t     p_quote;
	logic [7:0] p_digits;
	logic [2:0] p_ndigits;
	logic [5:0] p_argc;
	logic [1:0] p_redir;
	logic [1:0] p_err;
	bit         p_to_file;
	bit         p_halt;

	logic [7:0] line_q[$];

	// ---------------------------------------------------------------- predictor

	// A byte can cause at most four items; anything past that is dropped.
	function automatic void push_result(kind_t k, logic [7:0] b, logic [1:0] st,
			logic [1:0] rm, logic [5:0] ac);
		outcome_t r;
		if (step_out.size() >= MAX_RES)
			return;
		r.kind = k;
		r.data = b;
		r.status = st;
		r.redir = rm;
		r.count = ac;
		r.last = 1'b0;
		step_out.push_back(r);
	endfunction

	function automatic void emit_char(logic [7:0] b);
		push_result(p_to_file ? K_FILE : K_ARG, b, ST_OK, RD_NONE, 6'd0);
	endfunction

	function automatic bit is_blank(logic [7:0] b);
		return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic int hex_val(logic [7:0] b);
		if (b >= CH_DIG0 && b <= CH_DIG9)
			return int'(b - CH_DIG0);
		if (b >= CH_LO_A && b <= CH_LO_F)
			return b - CH_LO_A + 10;
		if (b >= CH_UP_A && b <= CH_UP_F)
			return b - CH_UP_A + 10;
		return -1;
	endfunction

	// Number of arguments the current slot count lets through.
	function automatic int arg_cap();
		if (p_arg_slots <= 1)
			return 0;
		if (p_arg_slots > 64)
			return 63;
		return p_arg_slots - 1;
	endfunction

	function automatic void clear_line();
		p_mode = LX_BETWEEN;
		p_quote = QT_NONE;
		p_digits = '0;
		p_ndigits = '0;
		p_argc = '0;
		p_redir = RD_NONE;
		p_err = ST_OK;
		p_to_file = 1'b0;
		p_halt = 1'b0;
	endfunction

	function automatic void abort_line(logic [1:0] code);
		p_err = code;
		p_halt = 1'b1;
	endfunction

	function automatic void end_word();
		emit_char(CH_NUL);
		if (!p_to_file)
			p_argc = p_argc + 6'd1;
		p_to_file = 1'b0;
		p_quote = QT_NONE;
		p_mode = LX_BETWEEN;
	endfunction

	function automatic void begin_word(logic [7:0] b);
		if (p_argc >= arg_cap()) begin
			p_halt = 1'b1;
			return;
		end
		if (b == CH_GT) begin
			p_redir = RD_NEW;
			p_mode = LX_REDIR1;
			return;
		end
		p_to_file = 1'b0;
		p_quote = QT_NONE;
		p_mode = LX_TOKEN;
		word_char(b);
	endfunction

	function automatic void begin_filename(logic [7:0] b);
		p_to_file = 1'b1;
		p_quote = QT_NONE;
		p_mode = LX_TOKEN;
		word_char(b);
	endfunction

	function automatic void word_char(logic [7:0] b);
		quote_t q;
		if (b == CH_BSLASH) begin
			if (p_quote == QT_SINGLE) begin
				emit_char(b);
				p_mode = LX_SQESC;
			end else begin
				p_mode = LX_ESC;
			end
		end else if (p_quote == QT_NONE && is_blank(b)) begin
			end_word();
		end else if (p_quote == QT_NONE && b == CH_GT) begin
			end_word();
			begin_word(b);
		end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
			q = (b == CH_SQUOTE) ? QT_SINGLE : QT_DOUBLE;
			if (p_quote == QT_NONE)
				p_quote = q;
			else if (p_quote == q)
				p_quote = QT_NONE;
			else
				emit_char(b);
		end else begin
			emit_char(b);
		end
	endfunction

	// Closes an octal or hex escape; a zero value is a bad escape.
	function automatic void finish_number();
		if (p_digits == 8'd0) begin
			abort_line(ST_ESCAPE);
			return;
		end
		emit_char(p_digits);
		p_mode = LX_TOKEN;
	endfunction

	function automatic void lex_char(logic [7:0] b);
		int h;
		case (p_mode)
			LX_TOKEN: word_char(b);
			LX_ESC: begin
				p_digits = '0;
				p_ndigits = '0;
				if (b == CH_LO_N) begin
					emit_char(CH_LF);
					p_mode = LX_TOKEN;
				end else if (b == CH_LO_R) begin
					emit_char(CH_CR);
					p_mode = LX_TOKEN;
				end else if (b == CH_DIG0) begin
					p_mode = LX_OCT;
				end else if (b == CH_LO_X) begin
					p_mode = LX_HEX;
				end else begin
					emit_char(b);
					p_mode = LX_TOKEN;
				end
			end
			LX_SQESC: begin
				emit_char(b);
				p_mode = LX_TOKEN;
			end
			LX_OCT: begin
				if (b >= CH_DIG0 && b <= CH_DIG7) begin
					p_digits = {p_digits[4:0], b[2:0]};
					p_ndigits = p_ndigits + 3'd1;
					if (p_ndigits >= 4)
						finish_number();
				end else if (p_ndigits < 2) begin
					abort_line(ST_ESCAPE);
				end else begin
					finish_number();
					if (!p_halt)
						word_char(b);
				end
			end
			LX_HEX: begin
				h = hex_val(b);
				if (h < 0) begin
					abort_line(ST_ESCAPE);
				end else begin
					p_digits = {p_digits[3:0], h[3:0]};
					p_ndigits = p_ndigits + 3'd1;
					if (p_ndigits >= 2)
						finish_number();
				end
			end
			LX_REDIR1: begin
				if (is_blank(b)) begin
					p_mode = LX_REDIRWAIT;
				end else if (b == CH_GT) begin
					p_redir = RD_APPEND;
					p_mode = LX_REDIRWAIT;
				end else begin
					begin_filename(b);
				end
			end
			LX_REDIRWAIT: begin
				if (is_blank(b)) begin
				end else if (b == CH_GT) begin
					// A redirect with nothing behind it gets an empty filename.
					p_to_file = 1'b1;
					emit_char(CH_NUL);
					p_to_file = 1'b0;
					p_mode = LX_BETWEEN;
					begin_word(b);
				end else begin
					begin_filename(b);
				end
			end
			default: begin
				p_mode = LX_BETWEEN;
				if (!is_blank(b))
					begin_word(b);
			end
		endcase
	endfunction

	function automatic void close_line();
		if (!p_halt) begin
			case (p_mode)
				LX_REDIR1, LX_REDIRWAIT: abort_line(ST_NOFILE);
				LX_HEX: abort_line(ST_ESCAPE);
				LX_OCT: begin
					if (p_ndigits < 2) begin
						abort_line(ST_ESCAPE);
					end else begin
						finish_number();
						if (!p_halt) begin
							if (p_quote != QT_NONE)
								abort_line(ST_QUOTE);
							else
								end_word();
						end
					end
				end
				LX_TOKEN, LX_ESC, LX_SQESC: begin
					if (p_quote != QT_NONE)
						abort_line(ST_QUOTE);
					else
						end_word();
				end
				default: ;
			endcase
		end
		push_result(K_END, CH_NUL, p_err, p_redir, p_argc);
		clear_line();
	endfunction

	// Works out every item one accepted byte causes and queues them in order.
	function automatic void tokenize_byte(logic [7:0] b, logic le);
		step_out.delete();
		if (b == CH_NUL) begin
			close_line();
		end else begin
			if (!p_halt)
				lex_char(b);
			if (le)
				close_line();
		end
		if (step_out.size() > 0)
			step_out[$].last = 1'b1;
		foreach (step_out[i])
			tokens_due.push_back(step_out[i]);
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (tokens_due.size() == 0) begin
				$error("output item with no prediction pending (kind %0d byte %0d)",
					kind, out_byte);
				error_count++;
			end else begin
				e = tokens_due.pop_front();
				check_field("kind", e.kind, kind);
				check_field("out_byte", e.data, out_byte);
				check_field("status", e.status, status);
				check_field("redirect_mode", e.redir, redirect_mode);
				check_field("arg_count", e.count, arg_count);
				check_field("run_last", e.last, run_last);
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Receiver: random stall bursts, plus long holds on request.
	initial begin
		int burst_left;
		int hold_left;
		int hold_seen;
		burst_left = 0;
		hold_left = 0;
		hold_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked != hold_seen) begin
				hold_seen = hold_asked;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				out_stall = 1'b1;
			end else if (idle_on && $urandom_range(0, 6) == 0) begin
				burst_left = $urandom_range(0, 4);
				out_stall = 1'b1;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	// Offers one byte, called and returning at a falling edge. The valid stays up
	// afterwards so that back-to-back bytes keep the channel busy.
	task automatic send_item(logic [7:0] b, logic le);
		if (idle_on && $urandom_range(0, 6) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid = 1'b1;
		byte_in = b;
		line_end = le;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tokenize_byte(b, le);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_line(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], i == s.len() - 1);
	endtask

	// Lowers valid and waits until every predicted item has come out, then lets
	// the lexer settle, since a byte that causes no item may still be in flight.
	task automatic wait_idle();
		in_valid = 1'b0;
		while (tokens_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_arg_slots(logic [6:0] v);
		wait_idle();
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		p_arg_slots = v;
	endtask

	task automatic test_plain_words();
		send_line("ab  cd\tef");
		// Byte extremes and the whitespace codes from tab to carriage return as separators.
		send_item(8'hFF, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'h80, 1'b0);
		for (int c = CH_TAB; c <= CH_CR; c++)
			send_item(c[7:0], 1'b0);
		send_item(8'h7F, 1'b1);
		send_line(" \t z ");
	endtask

	task automatic test_quotes();
		send_line("'a b'\"c'd\" e\"f g\"");
		send_line("'\\n\\''x");
		send_line("ok 'never closed");
	endtask

	task automatic test_escapes();
		send_line("\\n\\r\\q\\0101\\012z \\x4aB\\xFf");
		send_line("a\\x4g b");
		send_line("\\000 c");
		send_line("\\01z");
		send_line("a\\");
		send_line("b\\017");
		send_line("c\\07");
		send_line("d\\01");
		send_line("e\\x4");
		send_line("\"q\\xz\"");
	endtask

	task automatic test_redirects();
		send_line("a >f");
		send_line("b>>g c");
		send_line("> >h");
		send_line("c >");
		send_line("> x >> y");
		send_line("a>b");
	endtask

	// A zero byte ends the line on its own, with or without the line_end flag.
	task automatic test_zero_byte();
		send_item("a", 1'b0);
		send_item("b", 1'b0);
		send_item(CH_NUL, 1'b0);
		send_item("c", 1'b1);
		send_item("d", 1'b0);
		send_item(CH_NUL, 1'b1);
	endtask

	task automatic test_arg_limit();
		set_arg_slots(7'd2);
		send_line("a b c");
		set_arg_slots(7'd1);
		send_line("a b");
		set_arg_slots(7'd0);
		send_line("q");
		set_arg_slots(7'd127);
		send_line("x y");
		// 63 arguments reach the largest limit, which 64 slots give; the rest is cut.
		set_arg_slots(7'd64);
		for (int i = 0; i < 65; i++) begin
			send_item(8'("a" + i % 26), 1'b0);
			send_item(CH_SPACE, i == 64);
		end
		set_arg_slots(7'd16);
	endtask

	// The receiver holds off while the sender keeps offering bytes, so the
	// output buffer and the input register fill and in_stall rises. Then the
	// sender pauses until everything has drained.
	task automatic test_backpressure();
		wait_idle();
		hold_asked++;
		send_line("abcd efgh ijkl mnop qrst");
		wait_idle();
		send_line("uv >w");
	endtask

	function automatic void add_word();
		int n;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++)
			line_q.push_back(WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)]);
	endfunction

	function automatic void add_escape();
		int n;
		line_q.push_back(CH_BSLASH);
		case ($urandom_range(0, 4))
			0: line_q.push_back(CH_LO_N);
			1: line_q.push_back(CH_LO_R);
			2: line_q.push_back(8'($urandom_range(1, 255)));
			3: begin
				// Octal of two to four digits; a nonzero last digit keeps it nonzero.
				line_q.push_back(CH_DIG0);
				n = $urandom_range(2, 4);
				for (int i = 0; i < n - 1; i++)
					line_q.push_back(8'(CH_DIG0 + $urandom_range(0, 7)));
				line_q.push_back(8'(CH_DIG0 + $urandom_range(1, 7)));
			end
			default: begin
				line_q.push_back(CH_LO_X);
				line_q.push_back(HEX_CHARS[$urandom_range(0, 21)]);
				line_q.push_back(HEX_CHARS[$urandom_range(1, 21)]);
			end
		endcase
	endfunction

	function automatic void add_quoted();
		logic [7:0] q;
		int n;
		q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
		n = $urandom_range(1, 4);
		line_q.push_back(q);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 4))
				0: line_q.push_back(CH_SPACE);
				1: line_q.push_back(q == CH_SQUOTE ? CH_DQUOTE : CH_SQUOTE);
				2: add_escape();
				default: add_word();
			endcase
		end
		line_q.push_back(q);
	endfunction

	function automatic void add_redirect();
		line_q.push_back(CH_GT);
		if ($urandom_range(0, 2) == 0)
			line_q.push_back(CH_GT);
		if ($urandom_range(0, 1))
			line_q.push_back(CH_SPACE);
		if ($urandom_range(0, 5) != 0)
			add_word();
	endfunction

	// Sequences that end the line in error, or raw bytes of any value.
	function automatic void add_broken();
		case ($urandom_range(0, 4))
			0: begin
				line_q.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
				add_word();
			end
			1: begin
				line_q.push_back(CH_BSLASH);
				line_q.push_back(CH_LO_X);
				line_q.push_back("g");
			end
			2: begin
				line_q.push_back(CH_BSLASH);
				line_q.push_back(CH_DIG0);
				line_q.push_back($urandom_range(0, 1) ? "8" : "0");
				line_q.push_back(CH_DIG0);
			end
			3: line_q.push_back(CH_GT);
			default: begin
				repeat ($urandom_range(1, 3))
					line_q.push_back(8'($urandom_range(1, 255)));
			end
		endcase
	endfunction

	// Builds one command line, mostly well formed, and sends it. One line in
	// ten is closed by a zero byte instead of the line_end flag.
	task automatic send_random_line();
		int ntok;
		bit zero_end;
		line_q.delete();
		ntok = $urandom_range(1, 6);
		for (int t = 0; t < ntok; t++) begin
			case ($urandom_range(0, 11))
				0, 1, 2, 3: add_word();
				4, 5: add_quoted();
				6, 7: add_escape();
				8, 9: add_redirect();
				default: add_broken();
			endcase
			if ($urandom_range(0, 3) != 0) begin
				repeat ($urandom_range(1, 2))
					line_q.push_back($urandom_range(0, 1) ? CH_SPACE :
						8'($urandom_range(CH_TAB, CH_CR)));
			end
		end
		zero_end = ($urandom_range(0, 9) == 0);
		foreach (line_q[i])
			send_item(line_q[i], !zero_end && i == line_q.size() - 1);
		if (zero_end)
			send_item(CH_NUL, 1'($urandom_range(0, 1)));
	endtask

	task automatic random_phase(int count);
		int start;
		start = items_sent;
		while (items_sent - start < count)
			send_random_line();
	endtask

	task automatic test_random_lines();
		set_arg_slots(7'd64);
		random_phase(10);
		// Small settings make the argument limit bite often.
		set_arg_slots(7'($urandom_range(2, 6)));
		random_phase(10);
		set_arg_slots(7'($urandom_range(2, 64)));
		random_phase(10);
		// Last stretch runs at full rate on both sides.
		set_arg_slots(7'd16);
		idle_on = 1'b0;
		random_phase(10);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		byte_in = '0;
		line_end = 1'b0;
		p_arg_slots = 7'd16;
		clear_line();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_plain_words();
		test_quotes();
		test_escapes();
		test_redirects();
		test_zero_byte();
		test_arg_limit();
		test_backpressure();
		test_random_lines();

		wait_idle();
		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
